/* sv/four_joint_cascade_deadbeat_controller_unit_defines.svh */
// Assertion macros used by the deadbeat controller top level.
`ifndef FOUR_JOINT_CASCADE_DEADBEAT_CONTROLLER_UNIT_DEFINES_SVH
`define FOUR_JOINT_CASCADE_DEADBEAT_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk_i and disabled during reset.
`define FJCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i and disabled during reset.
`define FJCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/fjcd_pkg.sv */
// Shared types, constants and helpers of the deadbeat controller.
`default_nettype none

package fjcd_pkg;

  // Number of joints that get a datapath lane, and the fixed field count.
  localparam int JOINTS      = 4;
  localparam int NUM_ACTIONS = 4;

  localparam int GAIN_W    = 18;
  localparam int RATE_W    = 16;
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [DATA_W-1:0] q16_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POSITION_GAIN = 3'd0,
    CFG_VELOCITY_GAIN = 3'd1,
    CFG_SAMPLE_RATE   = 3'd2,
    CFG_INIT_JOINT_0  = 3'd3,
    CFG_INIT_JOINT_1  = 3'd4,
    CFG_INIT_JOINT_2  = 3'd5,
    CFG_INIT_JOINT_3  = 3'd6
  } cfg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [GAIN_W-1:0] POSITION_GAIN_RST = 18'd49152;
  localparam logic [GAIN_W-1:0] VELOCITY_GAIN_RST = 18'd32768;
  localparam logic [RATE_W-1:0] SAMPLE_RATE_RST   = 16'd100;
  localparam q16_t INIT_JOINT_RST [NUM_ACTIONS] = '{
    32'sd44499, 32'sd46411, 32'sd44846, 32'sd41756
  };

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN,
    ST_RATE1,
    ST_RATE2,
    ST_DELIVER
  } state_e;

  // Per-lane controls from the sequencer.
  typedef struct packed {
    logic ref_load;
    logic meas_load;
    logic init_load;
    logic gain_en;
    logic rate1_en;
    logic rate2_en;
  } lane_ctrl_t;

  localparam int WIDE_W = 56;
  localparam logic signed [WIDE_W-1:0] SAT_HI = 56'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_LO = -56'sd2147483648;

  // Saturate a wide signed value to the Q16.16 word range.
  function automatic q16_t sat32(input logic signed [WIDE_W-1:0] x);
    q16_t r;
    if (x > SAT_HI) begin
      r = 32'sh7FFFFFFF;
    end else if (x < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/fjcd_in_if.sv */
// Input channel: one reference or measurement item for all joints.
`default_nettype none

interface fjcd_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] joint_value_0;
  logic signed [31:0] joint_value_1;
  logic signed [31:0] joint_value_2;
  logic signed [31:0] joint_value_3;
  logic signed [31:0] joint_speed_0;
  logic signed [31:0] joint_speed_1;
  logic signed [31:0] joint_speed_2;
  logic signed [31:0] joint_speed_3;

  modport source (
    output valid, kind, joint_value_0, joint_value_1, joint_value_2, joint_value_3,
           joint_speed_0, joint_speed_1, joint_speed_2, joint_speed_3,
    input  ready
  );
  modport sink (
    input  valid, kind, joint_value_0, joint_value_1, joint_value_2, joint_value_3,
           joint_speed_0, joint_speed_1, joint_speed_2, joint_speed_3,
    output ready
  );
endinterface

`default_nettype wire

/* sv/fjcd_out_if.sv */
// Output channel: one item of control actions for all joints.
`default_nettype none

interface fjcd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] action_0;
  logic signed [31:0] action_1;
  logic signed [31:0] action_2;
  logic signed [31:0] action_3;

  modport source (
    output valid, action_0, action_1, action_2, action_3,
    input  ready
  );
  modport sink (
    input  valid, action_0, action_1, action_2, action_3,
    output ready
  );
endinterface

`default_nettype wire

/* sv/fjcd_lane.sv */
// One joint's cascade datapath with its history registers.
`default_nettype none

module fjcd_lane import fjcd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lane_ctrl_t        ctrl_i,
  input  logic [GAIN_W-1:0] k1_i,
  input  logic [GAIN_W-1:0] k2_i,
  input  logic [RATE_W-1:0] rate_i,
  input  q16_t              value_i,
  input  q16_t              speed_i,
  input  q16_t              init_i,
  input  q16_t              init_rst_i,
  output q16_t              action_o
);

  // History of the joint.
  q16_t ref_now_q, ref_before_q, pos_before_q, u1_before_q;
  // Captured measurement.
  q16_t pos_q, vel_q;

  // Pipeline registers.
  logic signed [51:0] p1_q, p1_d, p2_q, p2_d;
  logic signed [51:0] m1_q, m1_d;
  logic signed [37:0] b_q, b_d;
  logic signed [54:0] m2_q, m2_d;

  logic signed [32:0] d1, d2;
  logic signed [18:0] k1s, k2s;
  logic signed [16:0] rate_s;
  logic signed [51:0] rnd1, rnd2;
  logic signed [35:0] r1, r2;
  logic signed [37:0] a, u2;
  logic signed [34:0] a_c;
  q16_t               u1;

  // Gain products: last tracking error, and last u1 less measured velocity.
  always_comb begin
    k1s    = $signed({1'b0, k1_i});
    k2s    = $signed({1'b0, k2_i});
    rate_s = $signed({1'b0, rate_i});
    d1     = 33'(ref_before_q) - 33'(pos_before_q);
    d2     = 33'(u1_before_q) - 33'(vel_q);
    p1_d   = k1s * d1;
    p2_d   = k2s * d2;
  end

  // Round to Q16.16, form stage one, its rate product and the velocity term.
  always_comb begin
    rnd1 = p1_q + 52'sd32768;
    rnd2 = p2_q + 52'sd32768;
    r1   = $signed(rnd1[51:16]);
    r2   = $signed(rnd2[51:16]);
    a    = 38'(ref_now_q) - 38'(r1) - 38'(pos_before_q);
    if (a > 38'sd8589934592) begin
      a_c = 35'sd8589934592;
    end else if (a < -38'sd8589934592) begin
      a_c = -35'sd8589934592;
    end else begin
      a_c = a[34:0];
    end
    m1_d = a_c * rate_s;
    b_d  = 38'sd0 - 38'(r2) - 38'(vel_q);
  end

  // Second stage and the action.
  always_comb begin
    u1       = sat32(56'(m1_q));
    u2       = 38'(u1) + b_q;
    m2_d     = u2 * rate_s;
    action_o = sat32(56'(m2_q));
  end

  // Joint history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_now_q    <= '0;
      ref_before_q <= init_rst_i;
      pos_before_q <= init_rst_i;
      u1_before_q  <= '0;
    end else begin
      if (ctrl_i.ref_load) begin
        ref_now_q <= value_i;
      end
      if (ctrl_i.init_load) begin
        ref_before_q <= init_i;
        pos_before_q <= init_i;
      end
      if (ctrl_i.rate2_en) begin
        ref_before_q <= ref_now_q;
        pos_before_q <= pos_q;
        u1_before_q  <= u1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.meas_load) begin
      pos_q <= value_i;
      vel_q <= speed_i;
    end
    if (ctrl_i.gain_en) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
    if (ctrl_i.rate1_en) begin
      m1_q <= m1_d;
      b_q  <= b_d;
    end
    if (ctrl_i.rate2_en) begin
      m2_q <= m2_d;
    end
  end

endmodule

`default_nettype wire

/* sv/fjcd_merge.sv */
// Output register that gathers the lane actions into one result item.
`default_nettype none

module fjcd_merge import fjcd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  q16_t  action_i [NUM_ACTIONS],
  output logic  free_o,
  fjcd_out_if.source out_o
);

  logic out_valid_q;
  q16_t action_q [NUM_ACTIONS];

  // The register can take a new item when empty or being drained.
  assign free_o = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_i) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      action_q <= action_i;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.action_0 = action_q[0];
  assign out_o.action_1 = action_q[1];
  assign out_o.action_2 = action_q[2];
  assign out_o.action_3 = action_q[3];

endmodule

`default_nettype wire

/* sv/four_joint_cascade_deadbeat_controller_unit.sv */
// Top level of the four-joint cascade deadbeat controller.
// A measurement item steps through the gain, first rate and second rate states,
// then waits in the delivery state until the result register is free.
// A new measurement item is taken only when idle or as a result is delivered,
// so the lanes hold one item at a time. Reference items give no result.
// Reset clears the sequencer and history; the previous references and positions
// take the default init values and the gains and sample rate their defaults.
`default_nettype none
`include "four_joint_cascade_deadbeat_controller_unit_defines.svh"

module four_joint_cascade_deadbeat_controller_unit import fjcd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fjcd_in_if.sink              in_i,
  fjcd_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  state_e state_q, state_d;
  logic   seen_q;
  logic [GAIN_W-1:0] k1_q, k2_q;
  logic [RATE_W-1:0] rate_q;

  logic accept, start, ref_item, out_free, merge_load;
  q16_t value  [NUM_ACTIONS];
  q16_t speed  [NUM_ACTIONS];
  q16_t action [NUM_ACTIONS];
  lane_ctrl_t lane_ctrl [NUM_ACTIONS];

  // Input handshake and item classification.
  assign in_i.ready = (state_q == ST_IDLE) || (state_q == ST_DELIVER && out_free);
  assign accept     = in_i.valid && in_i.ready;
  assign ref_item   = accept && !in_i.kind;
  assign start      = accept && in_i.kind && seen_q;
  assign merge_load = (state_q == ST_DELIVER) && out_free;

  assign value[0] = in_i.joint_value_0;
  assign value[1] = in_i.joint_value_1;
  assign value[2] = in_i.joint_value_2;
  assign value[3] = in_i.joint_value_3;
  assign speed[0] = in_i.joint_speed_0;
  assign speed[1] = in_i.joint_speed_1;
  assign speed[2] = in_i.joint_speed_2;
  assign speed[3] = in_i.joint_speed_3;

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_GAIN;
        end
      end
      ST_GAIN:  state_d = ST_RATE1;
      ST_RATE1: state_d = ST_RATE2;
      ST_RATE2: state_d = ST_DELIVER;
      ST_DELIVER: begin
        if (out_free) begin
          state_d = start ? ST_GAIN : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Reference flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (ref_item) begin
      seen_q <= 1'b1;
    end
  end

  // Gain and rate registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_q   <= POSITION_GAIN_RST;
      k2_q   <= VELOCITY_GAIN_RST;
      rate_q <= SAMPLE_RATE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POSITION_GAIN: k1_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_VELOCITY_GAIN: k2_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_SAMPLE_RATE:   rate_q <= cfg_data_i[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Joint lanes; joints beyond the lane count report zero.
  for (genvar j = 0; j < NUM_ACTIONS; j++) begin : g_lane
    if (j < JOINTS) begin : g_on
      always_comb begin
        lane_ctrl[j].ref_load  = ref_item;
        lane_ctrl[j].meas_load = start;
        lane_ctrl[j].init_load = cfg_we_i && !seen_q &&
                                 (cfg_idx_i == CFG_IDX_W'(CFG_INIT_JOINT_0 + j));
        lane_ctrl[j].gain_en   = (state_q == ST_GAIN);
        lane_ctrl[j].rate1_en  = (state_q == ST_RATE1);
        lane_ctrl[j].rate2_en  = (state_q == ST_RATE2);
      end

      fjcd_lane u_lane (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (lane_ctrl[j]),
        .k1_i       (k1_q),
        .k2_i       (k2_q),
        .rate_i     (rate_q),
        .value_i    (value[j]),
        .speed_i    (speed[j]),
        .init_i     (cfg_data_i),
        .init_rst_i (INIT_JOINT_RST[j]),
        .action_o   (action[j])
      );
    end else begin : g_off
      assign lane_ctrl[j] = '0;
      assign action[j]    = '0;
    end
  end

  // Result register.
  fjcd_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (merge_load),
    .action_i (action),
    .free_o   (out_free),
    .out_o    (out_o)
  );

  // Checks.
  `FJCD_ASSERT_NEXT(a_start_gain, start, state_q == ST_GAIN,
                    "measurement item did not start the gain step")
  `FJCD_ASSERT_NEXT(a_rate2_deliver, state_q == ST_RATE2, state_q == ST_DELIVER,
                    "second rate step not followed by delivery")
  `FJCD_ASSERT_NEXT(a_load_valid, merge_load, out_o.valid,
                    "result register not valid after load")
  `FJCD_ASSERT_NOW(a_busy_stall,
                   state_q == ST_GAIN || state_q == ST_RATE1 || state_q == ST_RATE2,
                   !in_i.ready, "input accepted while lanes are busy")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench of the four-joint cascade deadbeat controller.
`default_nettype none

module tb_top import fjcd_pkg::*; ();

  typedef q16_t [NUM_ACTIONS-1:0] joint_vec_t;

  localparam logic KIND_REFERENCE   = 1'b0;
  localparam logic KIND_MEASUREMENT = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  localparam q16_t Q_MAX  = 32'sh7FFFFFFF;
  localparam q16_t Q_MIN  = 32'sh80000000;
  localparam q16_t Q_ONE  = 32'sh00010000;
  localparam q16_t Q_ZERO = 32'sh00000000;
  localparam q16_t Q_LSB  = 32'sh00000001;

  localparam longint SUM_LIM = 64'sd8589934592;
  localparam longint ACT_HI  = 64'sd2147483647;
  localparam longint ACT_LO  = -64'sd2147483648;

  localparam int TAIL_CYCLES  = 8;
  localparam int IDLE_LIMIT   = 1000;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 150;
  localparam int SHOWN_ERRORS = 10;

  typedef enum {ROW_CONFIG, ROW_ITEM} row_op_e;

  typedef struct {
    row_op_e                op;
    logic [CFG_IDX_W-1:0]   idx;
    logic [DATA_W-1:0]      data;
    logic                   kind;
    joint_vec_t             val;
    joint_vec_t             spd;
    bit                     typed;
    joint_vec_t             typed_act;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_data_i;

  fjcd_in_if  in_if ();
  fjcd_out_if out_if ();

  four_joint_cascade_deadbeat_controller_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor copy of the configuration and the per-joint history.
  longint k_pos;
  longint k_vel;
  longint rate_hz;
  longint seed     [NUM_ACTIONS];
  longint cmd_ref  [NUM_ACTIONS];
  longint last_ref [NUM_ACTIONS];
  longint last_pos [NUM_ACTIONS];
  longint last_u1  [NUM_ACTIONS];
  bit     have_ref;

  joint_vec_t pending_actions [$];
  stim_row_t  stim_rows [$];
  joint_vec_t predicted_action;
  joint_vec_t seen_action;
  bit         item_typed = 1'b0;
  joint_vec_t item_typed_action = '0;
  int         failure_count = 0;
  int         idle_cycles = 0;
  int         burst_left = 0;
  bit         sender_steady = 1'b0;
  logic [15:0] stall_mask = '1;
  logic [5:0]  stall_step = '0;

  // Q.32 product to Q16.16, nearest, ties toward plus infinity.
  function automatic longint round_half_up(input longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic longint limit_to(input longint x, input longint lo, input longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // One controller step; returns 1 when the item produces an action item.
  function automatic bit deadbeat_step(input logic kind, input joint_vec_t val,
                                       input joint_vec_t spd, output joint_vec_t act);
    longint a;
    longint u1;
    longint u2;
    longint pos;
    longint vel;
    longint r;
    q16_t   w;
    act = '0;
    if (kind == KIND_REFERENCE) begin
      for (int j = 0; j < JOINTS; j++) begin
        w = val[j];
        cmd_ref[j] = longint'(w);
      end
      have_ref = 1'b1;
      return 1'b0;
    end
    if (!have_ref) return 1'b0;
    for (int j = 0; j < JOINTS; j++) begin
      w = val[j];
      pos = longint'(w);
      w = spd[j];
      vel = longint'(w);
      a = cmd_ref[j] - round_half_up(k_pos * (last_ref[j] - last_pos[j])) - last_pos[j];
      a = limit_to(a, -SUM_LIM, SUM_LIM);
      u1 = limit_to(a * rate_hz, ACT_LO, ACT_HI);
      u2 = u1 - round_half_up(k_vel * (last_u1[j] - vel)) - vel;
      r = limit_to(u2 * rate_hz, ACT_LO, ACT_HI);
      act[j] = r[31:0];
      last_ref[j] = cmd_ref[j];
      last_pos[j] = pos;
      last_u1[j] = u1;
    end
    return 1'b1;
  endfunction

  // Register write as seen by the predictor.
  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [DATA_W-1:0] data);
    q16_t w;
    int   j;
    case (idx)
      CFG_POSITION_GAIN: begin
        k_pos = longint'(data[GAIN_W-1:0]);
      end
      CFG_VELOCITY_GAIN: begin
        k_vel = longint'(data[GAIN_W-1:0]);
      end
      CFG_SAMPLE_RATE: begin
        rate_hz = longint'(data[RATE_W-1:0]);
      end
      CFG_INIT_JOINT_0, CFG_INIT_JOINT_1, CFG_INIT_JOINT_2, CFG_INIT_JOINT_3: begin
        j = int'(idx) - int'(CFG_INIT_JOINT_0);
        w = data;
        seed[j] = longint'(w);
        // The seed only reaches the history while no reference has arrived.
        if (!have_ref) begin
          last_ref[j] = seed[j];
          last_pos[j] = seed[j];
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void note_failure(input string msg);
    failure_count++;
    if (failure_count <= SHOWN_ERRORS) $display("ERROR: %s", msg);
  endfunction

  // Random word: mostly moderate values, some full range, some extremes.
  function automatic q16_t rand_word();
    q16_t w;
    case ($urandom_range(0, 7))
      0, 1: begin
        w = $urandom();
      end
      2: begin
        case ($urandom_range(0, 3))
          0: w = Q_MAX;
          1: w = Q_MIN;
          2: w = Q_ZERO;
          default: w = -Q_LSB;
        endcase
      end
      default: begin
        w = q16_t'($urandom_range(0, 33554431)) - 32'sd16777216;
      end
    endcase
    return w;
  endfunction

  function automatic void add_config_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [DATA_W-1:0] data);
    stim_row_t row;
    row = '{ROW_CONFIG, idx, data, KIND_REFERENCE, '0, '0, 1'b0, '0};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_item_row(input logic kind, input joint_vec_t val,
                                       input joint_vec_t spd, input bit typed,
                                       input joint_vec_t typed_act);
    stim_row_t row;
    row = '{ROW_ITEM, CFG_UNMAPPED, '0, kind, val, spd, typed, typed_act};
    stim_rows.push_back(row);
  endfunction

  task automatic put_item(input logic kind, input joint_vec_t val, input joint_vec_t spd);
    in_if.kind          = kind;
    in_if.joint_value_0 = val[0];
    in_if.joint_value_1 = val[1];
    in_if.joint_value_2 = val[2];
    in_if.joint_value_3 = val[3];
    in_if.joint_speed_0 = spd[0];
    in_if.joint_speed_1 = spd[1];
    in_if.joint_speed_2 = spd[2];
    in_if.joint_speed_3 = spd[3];
  endtask

  // Offer one item in bursts with random gaps; returns at the falling edge after acceptance.
  task automatic send_item(input logic kind, input joint_vec_t val, input joint_vec_t spd,
                           input bit typed, input joint_vec_t typed_act);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = sender_steady ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        in_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    put_item(kind, val, spd);
    item_typed = typed;
    item_typed_action = typed_act;
    in_if.valid = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    burst_left--;
  endtask

  // Let the block run dry before a register write.
  task automatic settle();
    in_if.valid = 1'b0;
    while (pending_actions.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    apply_register(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: ready follows a 16-bit mask, stepped bit by bit and redrawn each time the 6-bit step counter wraps.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_step == 0) begin
        case ($urandom_range(0, 3))
          0: stall_mask = '1;
          1: stall_mask = 16'($urandom()) | 16'h0001;
          2: stall_mask = ~(16'h0001 << $urandom_range(0, 15));
          default: stall_mask = 16'h8001 | (16'h0001 << $urandom_range(0, 15));
        endcase
      end
      out_if.ready = stall_mask[stall_step[3:0]];
      stall_step++;
    end
  end

  // Accepted inputs feed the predictor; accepted action items are checked in order.
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      if (deadbeat_step(in_if.kind,
                        {in_if.joint_value_3, in_if.joint_value_2,
                         in_if.joint_value_1, in_if.joint_value_0},
                        {in_if.joint_speed_3, in_if.joint_speed_2,
                         in_if.joint_speed_1, in_if.joint_speed_0},
                        predicted_action)) begin
        pending_actions.push_back(item_typed ? item_typed_action : predicted_action);
      end
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen_action = {out_if.action_3, out_if.action_2, out_if.action_1, out_if.action_0};
      if (pending_actions.size() == 0) begin
        note_failure($sformatf("action item %h with none expected", seen_action));
      end else begin
        predicted_action = pending_actions.pop_front();
        for (int j = 0; j < NUM_ACTIONS; j++) begin
          if (seen_action[j] !== predicted_action[j]) begin
            note_failure($sformatf("action_%0d expected %h got %h",
                                   j, predicted_action[j], seen_action[j]));
          end
        end
      end
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles without any handshake.
  initial begin
    do @(posedge clk_i); while (idle_cycles < IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Stimulus.
  initial begin
    logic       kind;
    joint_vec_t val;
    joint_vec_t spd;
    logic [DATA_W-1:0] gp;
    logic [DATA_W-1:0] gv;
    logic [DATA_W-1:0] rt;

    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_UNMAPPED;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    put_item(KIND_REFERENCE, '0, '0);

    k_pos    = longint'(POSITION_GAIN_RST);
    k_vel    = longint'(VELOCITY_GAIN_RST);
    rate_hz  = longint'(SAMPLE_RATE_RST);
    have_ref = 1'b0;
    for (int j = 0; j < NUM_ACTIONS; j++) begin
      seed[j]     = longint'(INIT_JOINT_RST[j]);
      cmd_ref[j]  = 0;
      last_ref[j] = seed[j];
      last_pos[j] = seed[j];
      last_u1[j]  = 0;
    end

    // Directed rows.
    // A measurement ahead of any reference produces nothing.
    add_item_row(KIND_MEASUREMENT, {Q_ONE, -Q_ONE, Q_MAX, Q_MIN}, {4{Q_ONE}}, 1'b0, '0);
    // Before any reference, an init write also seeds that joint's history.
    add_config_row(CFG_INIT_JOINT_0, 32'h7FFFFFFF);
    add_item_row(KIND_REFERENCE, {4{Q_MIN}}, {4{Q_MAX}}, 1'b0, '0);
    // Largest downward step drives both stages to negative saturation.
    add_item_row(KIND_MEASUREMENT, '0, '0, 1'b1, {4{Q_MIN}});
    add_item_row(KIND_REFERENCE, {4{Q_MAX}}, '0, 1'b0, '0);
    // Largest upward step with the lowest velocity saturates high.
    add_item_row(KIND_MEASUREMENT, {4{Q_MIN}}, {4{Q_MIN}}, 1'b1, {4{Q_MAX}});
    add_item_row(KIND_MEASUREMENT, {Q_ONE, Q_ZERO, -Q_LSB, Q_MAX}, {4{Q_MAX}}, 1'b0, '0);
    // A zero sample rate forces every action to zero.
    add_config_row(CFG_SAMPLE_RATE, 32'h0);
    add_item_row(KIND_MEASUREMENT, {Q_MAX, Q_MIN, Q_ZERO, Q_ONE},
                 {Q_MIN, Q_MAX, -Q_ONE, Q_ZERO}, 1'b1, '0);
    // Writes to an unmapped index are dropped.
    add_config_row(CFG_UNMAPPED, 32'hFFFFFFFF);
    add_config_row(CFG_SAMPLE_RATE, 32'h0000FFFF);
    add_config_row(CFG_POSITION_GAIN, 32'h0003FFFF);
    add_config_row(CFG_VELOCITY_GAIN, 32'h0003FFFF);
    add_item_row(KIND_REFERENCE, {Q_ONE, -Q_ONE, Q_ZERO, -Q_LSB}, '0, 1'b0, '0);
    add_item_row(KIND_MEASUREMENT, {Q_ZERO, Q_ONE, -Q_LSB, Q_LSB},
                 {Q_LSB, -Q_LSB, Q_ZERO, Q_ONE}, 1'b0, '0);
    add_item_row(KIND_MEASUREMENT, '0, '0, 1'b0, '0);
    // Half gains on odd unit steps land exactly on rounding ties.
    add_config_row(CFG_POSITION_GAIN, 32'h00008000);
    add_config_row(CFG_VELOCITY_GAIN, 32'h00008000);
    add_config_row(CFG_SAMPLE_RATE, 32'h00000001);
    add_item_row(KIND_REFERENCE, {Q_LSB, -Q_LSB, 32'sd3, -32'sd3}, '0, 1'b0, '0);
    add_item_row(KIND_MEASUREMENT, '0, '0, 1'b0, '0);
    add_item_row(KIND_MEASUREMENT, {Q_LSB, -Q_LSB, Q_LSB, -Q_LSB},
                 {-Q_LSB, Q_LSB, 32'sd3, -32'sd3}, 1'b0, '0);
    add_item_row(KIND_MEASUREMENT, {-Q_LSB, Q_LSB, Q_ZERO, Q_ZERO},
                 {Q_LSB, Q_LSB, -Q_LSB, -Q_LSB}, 1'b0, '0);
    // Once a reference is in, init writes leave the history untouched.
    add_config_row(CFG_INIT_JOINT_1, 32'h80000000);
    add_config_row(CFG_INIT_JOINT_2, 32'h00000000);
    add_config_row(CFG_INIT_JOINT_3, 32'h7FFFFFFF);
    add_item_row(KIND_MEASUREMENT, {Q_ONE, Q_ONE, Q_ONE, Q_ONE}, '0, 1'b0, '0);

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed rows.
    foreach (stim_rows[i]) begin
      if (stim_rows[i].op == ROW_CONFIG) begin
        settle();
        write_register(stim_rows[i].idx, stim_rows[i].data);
      end else begin
        send_item(stim_rows[i].kind, stim_rows[i].val, stim_rows[i].spd,
                  stim_rows[i].typed, stim_rows[i].typed_act);
      end
    end

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      settle();
      sender_steady = (phase % 3 == 1);
      case (phase)
        0: begin
          gp = 32'h0003FFFF;
          gv = 32'h0003FFFF;
          rt = 32'h0000FFFF;
        end
        1: begin
          gp = '0;
          gv = '0;
          rt = 32'h00000001;
        end
        2: begin
          gp = $urandom_range(0, 196607);
          gv = $urandom_range(0, 196607);
          rt = '0;
        end
        default: begin
          gp = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 196607);
          gv = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 196607);
          rt = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 400);
        end
      endcase
      write_register(CFG_POSITION_GAIN, gp);
      write_register(CFG_VELOCITY_GAIN, gv);
      write_register(CFG_SAMPLE_RATE, rt);
      for (int j = 0; j < NUM_ACTIONS; j++) begin
        write_register(CFG_IDX_W'(CFG_INIT_JOINT_0 + j), rand_word());
      end
      if ($urandom_range(0, 1) == 1) write_register(CFG_UNMAPPED, $urandom());

      // Mostly measurements, with a fresh reference now and then.
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = ($urandom_range(0, 5) == 0) ? KIND_REFERENCE : KIND_MEASUREMENT;
        for (int j = 0; j < NUM_ACTIONS; j++) begin
          val[j] = rand_word();
          spd[j] = rand_word();
        end
        send_item(kind, val, spd, 1'b0, '0);
      end
    end

    // Drain, then wait TAIL_CYCLES for stray results.
    in_if.valid = 1'b0;
    while (pending_actions.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (failure_count == 0 && pending_actions.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+sv
sv/fjcd_pkg.sv
sv/fjcd_in_if.sv
sv/fjcd_out_if.sv
sv/fjcd_lane.sv
sv/fjcd_merge.sv
sv/four_joint_cascade_deadbeat_controller_unit.sv
tb/tb_top.sv
